// File: rtl/u8sa_pkg.sv
// ----------------------------------------------------------------------------
// u8sa_pkg
// Shared types, status codes and lead byte decoding for the UTF-8 assembler.
// ----------------------------------------------------------------------------
package u8sa_pkg;

  // Result status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_LEAD = 3'd1;
  localparam logic [2:0] ST_BAD_CONT = 3'd2;
  localparam logic [2:0] ST_TRUNC    = 3'd3;
  localparam logic [2:0] ST_ZERO     = 3'd4;

  localparam int unsigned MAX_LEN = 6;
  localparam int unsigned CHAR_W  = 8 * MAX_LEN;

  // Assembler state carried between bytes.
  typedef struct packed {
    logic [CHAR_W-1:0] gathered;
    logic [2:0]        expected;
    logic [2:0]        count;
    logic              halted;
  } state_t;

  // One result beat.
  typedef struct packed {
    logic [CHAR_W-1:0] char_bytes;
    logic [2:0]        char_length;
    logic [2:0]        status;
  } result_t;

  // Sequence length encoded by a lead byte; zero for a malformed lead.
  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd0;
    if (b[7] == 1'b0) begin
      len = 3'd1;
    end else if (b[7:5] == 3'b110) begin
      len = 3'd2;
    end else if (b[7:4] == 4'b1110) begin
      len = 3'd3;
    end else if (b[7:3] == 5'b11110) begin
      len = 3'd4;
    end else if (b[7:2] == 6'b111110) begin
      len = 3'd5;
    end else if (b[7:1] == 7'b1111110) begin
      len = 3'd6;
    end
    return len;
  endfunction

endpackage

// File: rtl/u8sa_ifs.sv
// ----------------------------------------------------------------------------
// u8sa channel interfaces
// Valid/ready channels for the byte input and the character output.
// ----------------------------------------------------------------------------
interface u8sa_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_string;

  modport source (output valid, data_byte, end_of_string, input ready);
  modport sink   (input valid, data_byte, end_of_string, output ready);
endinterface

interface u8sa_char_if;
  logic        valid;
  logic        ready;
  logic [47:0] char_bytes;
  logic [2:0]  char_length;
  logic [2:0]  status;

  modport source (output valid, char_bytes, char_length, status, input ready);
  modport sink   (input valid, char_bytes, char_length, status, output ready);
endinterface

// File: rtl/u8sa_decode.sv
// ----------------------------------------------------------------------------
// u8sa_decode
// Next-state and result logic for one byte of the UTF-8 stream.
// ----------------------------------------------------------------------------
module u8sa_decode (
  input  u8sa_pkg::state_t  cur,
  input  logic [7:0]        data_byte,
  input  logic              end_of_string,
  output u8sa_pkg::state_t  nxt,
  output logic              res_valid,
  output u8sa_pkg::result_t res
);

  logic [2:0]                  lead_len;
  logic [2:0]                  pos;
  logic [2:0]                  count_next;
  logic [u8sa_pkg::CHAR_W-1:0] merged;

  assign lead_len   = u8sa_pkg::lead_length(data_byte);
  // Continuation bytes beyond the sixth land in the last byte lane.
  assign pos        = (cur.count > 3'd5) ? 3'd5 : cur.count;
  assign count_next = pos + 3'd1;

  // Place the continuation byte into its lane of the gathered word.
  always_comb begin
    merged = cur.gathered;
    for (int i = 0; i < u8sa_pkg::MAX_LEN; i++) begin
      if (pos == i[2:0]) begin
        merged[8*i +: 8] = cur.gathered[8*i +: 8] | data_byte;
      end
    end
  end

  // Byte handling: lead, continuation or ignored while halted.
  always_comb begin
    nxt       = cur;
    res_valid = 1'b0;
    res       = '0;
    if (cur.halted) begin
      res_valid = 1'b0;
    end else if (cur.expected == 3'd0) begin
      if (data_byte == 8'h00) begin
        res_valid  = 1'b1;
        res.status = u8sa_pkg::ST_ZERO;
        nxt.halted = 1'b1;
      end else if (lead_len == 3'd0) begin
        res_valid  = 1'b1;
        res.status = u8sa_pkg::ST_BAD_LEAD;
        nxt.halted = 1'b1;
      end else if (lead_len == 3'd1) begin
        res_valid       = 1'b1;
        res.char_bytes  = {{(u8sa_pkg::CHAR_W-8){1'b0}}, data_byte};
        res.char_length = 3'd1;
        res.status      = u8sa_pkg::ST_OK;
      end else if (end_of_string) begin
        res_valid  = 1'b1;
        res.status = u8sa_pkg::ST_TRUNC;
      end else begin
        nxt.gathered = {{(u8sa_pkg::CHAR_W-8){1'b0}}, data_byte};
        nxt.expected = lead_len;
        nxt.count    = 3'd1;
      end
    end else if (data_byte[7:6] != 2'b10) begin
      res_valid  = 1'b1;
      res.status = u8sa_pkg::ST_BAD_CONT;
      nxt        = '0;
      nxt.halted = 1'b1;
    end else if (count_next >= cur.expected) begin
      res_valid       = 1'b1;
      res.char_bytes  = merged;
      res.char_length = cur.expected;
      res.status      = u8sa_pkg::ST_OK;
      nxt             = '0;
    end else begin
      nxt.gathered = merged;
      nxt.count    = count_next;
      if (end_of_string) begin
        res_valid  = 1'b1;
        res.status = u8sa_pkg::ST_TRUNC;
      end
    end
    // The end flag returns everything to the reset state.
    if (end_of_string) begin
      nxt = '0;
    end
  end

endmodule

// File: rtl/utf8_sequence_assembler_unit.sv
// ----------------------------------------------------------------------------
// utf8_sequence_assembler_unit
// Flow: a byte taken into the input register is decoded there; its result beat
// is written to the result register once that slot is free, and is offered from it.
// Throughput: one byte per cycle while the output side keeps taking beats.
// The pace is set by the single decode stage between the input register and
// the result register. Synchronous reset clears the stages and assembler state.
// ----------------------------------------------------------------------------
module utf8_sequence_assembler_unit (
  input logic          clk,
  input logic          rst,
  u8sa_byte_if.sink    byte_stream,
  u8sa_char_if.source  char_stream
);

  logic              s1_valid;
  logic [7:0]        s1_byte;
  logic              s1_eos;
  u8sa_pkg::state_t  st;
  u8sa_pkg::state_t  st_next;
  logic              res_valid;
  u8sa_pkg::result_t res;
  logic              out_valid;
  u8sa_pkg::result_t out_res;
  logic              out_free;
  logic              advance;
  logic              in_ready;

  // Stage handshakes: the input register drains whenever the result slot frees.
  assign out_free = !out_valid || char_stream.ready;
  assign advance  = s1_valid && out_free;
  assign in_ready = !s1_valid || advance;

  assign byte_stream.ready = in_ready;

  u8sa_decode u_decode (
    .cur           (st),
    .data_byte     (s1_byte),
    .end_of_string (s1_eos),
    .nxt           (st_next),
    .res_valid     (res_valid),
    .res           (res)
  );

  // Control state and assembler state.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      st        <= '0;
    end else begin
      if (in_ready) begin
        s1_valid <= byte_stream.valid;
      end
      if (advance) begin
        st <= st_next;
      end
      if (out_free) begin
        out_valid <= advance && res_valid;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_ready && byte_stream.valid) begin
      s1_byte <= byte_stream.data_byte;
      s1_eos  <= byte_stream.end_of_string;
    end
    if (advance && res_valid) begin
      out_res <= res;
    end
  end

  assign char_stream.valid       = out_valid;
  assign char_stream.char_bytes  = out_res.char_bytes;
  assign char_stream.char_length = out_res.char_length;
  assign char_stream.status      = out_res.status;

endmodule

// File: bench/tb_utf8_sequence_assembler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_sequence_assembler_unit
// Self-checking bench for the UTF-8 sequence assembler. A clocked driver feeds
// bytes from a queue over the byte channel and predicts each result as the
// beat is taken. A clocked monitor checks every character beat against the
// oldest prediction. Both sides insert random gaps, except in one quiet stretch.
// ----------------------------------------------------------------------------
module tb_utf8_sequence_assembler_unit;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_BYTES = 800;

  // Ways a random string is broken on purpose.
  typedef enum int unsigned {
    FAULT_ZERO,
    FAULT_LEAD,
    FAULT_CONT,
    FAULT_TRUNC
  } fault_kind_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       drain_first;
  } stream_byte_t;

  logic clk;
  logic rst;

  u8sa_byte_if byte_ch ();
  u8sa_char_if char_ch ();

  utf8_sequence_assembler_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .byte_stream (byte_ch),
    .char_stream (char_ch)
  );

  // Byte stream still to be sent and characters still to arrive.
  stream_byte_t      byte_queue[$];
  u8sa_pkg::result_t char_expect[$];

  // Shadow of the assembler state.
  logic [47:0] gathered;
  logic [2:0]  seq_expected;
  logic [2:0]  seq_count;
  logic        halted;

  stream_byte_t drv_item;
  logic         drv_busy;
  logic         hold_next;
  int unsigned  bytes_taken;
  int unsigned  results_seen;
  int unsigned  mismatch_count;
  int unsigned  cycle_count;
  int unsigned  string_count;
  int unsigned  status_seen[0:4];

  // Clock with a 4 ns period.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Sequence length announced by a lead byte; zero when the lead is malformed.
  function automatic logic [2:0] seq_length(input logic [7:0] b);
    casez (b)
      8'b0???????: return 3'd1;
      8'b110?????: return 3'd2;
      8'b1110????: return 3'd3;
      8'b11110???: return 3'd4;
      8'b111110??: return 3'd5;
      8'b1111110?: return 3'd6;
      default:     return 3'd0;
    endcase
  endfunction

  // Random lead byte for a character of n bytes; never the zero terminator.
  function automatic logic [7:0] random_lead(input int unsigned n);
    logic [7:0] r;
    r = 8'($urandom);
    case (n)
      1: return (r[6:0] == 7'd0) ? 8'h20 : {1'b0, r[6:0]};
      2: return {3'b110, r[4:0]};
      3: return {4'b1110, r[3:0]};
      4: return {5'b11110, r[2:0]};
      5: return {6'b111110, r[1:0]};
      default: return {7'b1111110, r[0]};
    endcase
  endfunction

  function automatic logic [7:0] random_cont();
    return {2'b10, 6'($urandom)};
  endfunction

  // Gaps are suppressed while the middle of the stream goes through.
  function automatic bit take_gap();
    return (bytes_taken < 300 || bytes_taken >= 500) && $urandom_range(0, 99) < 8;
  endfunction

  function automatic void push_byte(input logic [7:0] d, input logic l);
    byte_queue.push_back('{data: d, last: l, drain_first: hold_next});
    hold_next = 1'b0;
  endfunction

  function automatic void flag_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("[%0t] MISMATCH %s", $realtime, what);
    end
  endfunction

  // Advance the shadow state by one accepted byte and queue any result.
  function automatic void predict_byte(input logic [7:0] b, input logic l);
    logic [2:0]        len;
    logic [2:0]        pos;
    u8sa_pkg::result_t res;
    logic              produce;
    res = '0;
    produce = 1'b0;
    if (halted) begin
      // Everything is dropped until the end of the string.
    end else if (seq_expected == 3'd0) begin
      len = seq_length(b);
      if (b == 8'h00) begin
        res.status = u8sa_pkg::ST_ZERO;
        produce = 1'b1;
        halted = 1'b1;
      end else if (len == 3'd0) begin
        res.status = u8sa_pkg::ST_BAD_LEAD;
        produce = 1'b1;
        halted = 1'b1;
      end else if (len == 3'd1) begin
        res.char_bytes = {40'd0, b};
        res.char_length = 3'd1;
        res.status = u8sa_pkg::ST_OK;
        produce = 1'b1;
      end else if (l) begin
        res.status = u8sa_pkg::ST_TRUNC;
        produce = 1'b1;
      end else begin
        gathered = {40'd0, b};
        seq_expected = len;
        seq_count = 3'd1;
      end
    end else if (b[7:6] != 2'b10) begin
      // The offending byte is not taken as a new lead.
      res.status = u8sa_pkg::ST_BAD_CONT;
      produce = 1'b1;
      halted = 1'b1;
      gathered = '0;
      seq_expected = 3'd0;
      seq_count = 3'd0;
    end else begin
      pos = (seq_count > 3'd5) ? 3'd5 : seq_count;
      gathered = gathered | (48'(b) << (8 * pos));
      seq_count = pos + 3'd1;
      if (seq_count >= seq_expected) begin
        res.char_bytes = gathered;
        res.char_length = seq_expected;
        res.status = u8sa_pkg::ST_OK;
        produce = 1'b1;
        gathered = '0;
        seq_expected = 3'd0;
        seq_count = 3'd0;
      end else if (l) begin
        res.status = u8sa_pkg::ST_TRUNC;
        produce = 1'b1;
      end
    end
    // The end flag returns the assembler to its reset state.
    if (l) begin
      gathered = '0;
      seq_expected = 3'd0;
      seq_count = 3'd0;
      halted = 1'b0;
    end
    if (produce) begin
      char_expect.push_back(res);
    end
  endfunction

  // Byte driver: predicts each beat as it is taken, then presents the next one.
  always @(posedge clk) begin
    if (rst) begin
      byte_ch.valid <= 1'b0;
      byte_ch.data_byte <= 8'h00;
      byte_ch.end_of_string <= 1'b0;
      drv_busy = 1'b0;
    end else begin
      if (byte_ch.valid && byte_ch.ready) begin
        predict_byte(drv_item.data, drv_item.last);
        bytes_taken++;
        drv_busy = 1'b0;
      end
      if (!drv_busy && byte_queue.size() != 0) begin
        if (byte_queue[0].drain_first && char_expect.size() != 0) begin
          // Hold off until every outstanding character has come back.
        end else if (!take_gap()) begin
          drv_item = byte_queue.pop_front();
          drv_busy = 1'b1;
        end
      end
      byte_ch.valid <= drv_busy;
      byte_ch.data_byte <= drv_item.data;
      byte_ch.end_of_string <= drv_item.last;
    end
  end

  // Character monitor: compares each beat with the oldest prediction.
  always @(posedge clk) begin : watch
    u8sa_pkg::result_t want;
    if (rst) begin
      char_ch.ready <= 1'b0;
    end else begin
      if (char_ch.valid && char_ch.ready) begin
        results_seen++;
        if (char_ch.status <= u8sa_pkg::ST_ZERO) begin
          status_seen[char_ch.status]++;
        end
        if (char_expect.size() == 0) begin
          flag_mismatch($sformatf("unexpected beat bytes=%h len=%0d status=%0d",
                                  char_ch.char_bytes, char_ch.char_length, char_ch.status));
        end else begin
          want = char_expect.pop_front();
          if (char_ch.char_bytes !== want.char_bytes) begin
            flag_mismatch($sformatf("char_bytes expected %h got %h",
                                    want.char_bytes, char_ch.char_bytes));
          end
          if (char_ch.char_length !== want.char_length) begin
            flag_mismatch($sformatf("char_length expected %0d got %0d",
                                    want.char_length, char_ch.char_length));
          end
          if (char_ch.status !== want.status) begin
            flag_mismatch($sformatf("status expected %0d got %0d",
                                    want.status, char_ch.status));
          end
        end
      end
      char_ch.ready <= !take_gap();
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results pending", cycle_count,
               char_expect.size());
      $display("tb_utf8_sequence_assembler_unit failed");
      $finish;
    end
  end

  initial begin : stimulus
    // Directed bytes; bit 8 carries the end flag.
    logic [8:0]  directed[];
    int unsigned counted;
    int unsigned nchars;
    int unsigned len;
    int unsigned cut;
    fault_kind_t fault;
    logic [7:0]  b;

    directed = '{
      9'h000, 9'h1FF,                                 // terminator, then ignored
      9'h080, 9'h141,                                 // stray continuation as lead
      9'h1FE,                                         // invalid lead with end flag
      9'h07F, 9'h001,                                 // single-byte extremes
      9'h0FD, 9'h080, 9'h0BF, 9'h080, 9'h0BF, 9'h180, // six-byte form ends string
      9'h0FB, 9'h080, 9'h180,                         // five-byte form cut short
      9'h1C2,                                         // lead alone on the last byte
      9'h0E0, 9'h000, 9'h1F0,                         // zero in place of continuation
      9'h0DF, 9'h1C0,                                 // bad continuation on last byte
      9'h0F7, 9'h0BF, 9'h0BF, 9'h1BF                  // four-byte form
    };

    rst = 1'b1;
    byte_ch.valid = 1'b0;
    byte_ch.data_byte = 8'h00;
    byte_ch.end_of_string = 1'b0;
    char_ch.ready = 1'b0;
    gathered = '0;
    seq_expected = 3'd0;
    seq_count = 3'd0;
    halted = 1'b0;
    drv_busy = 1'b0;
    drv_item = '{data: 8'h00, last: 1'b0, drain_first: 1'b0};
    hold_next = 1'b0;
    bytes_taken = 0;
    results_seen = 0;
    mismatch_count = 0;
    cycle_count = 0;
    string_count = 0;
    counted = 0;
    foreach (status_seen[i]) status_seen[i] = 0;

    foreach (directed[i]) begin
      push_byte(directed[i][7:0], directed[i][8]);
    end

    // Random strings: mostly well-formed characters, some broken on purpose.
    hold_next = 1'b1;
    while (counted < RANDOM_BYTES) begin
      if (counted >= RANDOM_BYTES / 2 && counted < RANDOM_BYTES / 2 + 10) begin
        hold_next = 1'b1;
      end
      string_count++;
      nchars = $urandom_range(1, 8);
      for (int unsigned c = 0; c < nchars; c++) begin
        len = $urandom_range(1, 6);
        if ($urandom_range(0, 99) < 12) begin
          // Plain random byte as noise.
          push_byte(8'($urandom), 1'b0);
          counted++;
        end else if ($urandom_range(0, 99) < 6) begin
          fault = fault_kind_t'($urandom_range(0, 3));
          case (fault)
            FAULT_ZERO: begin
              push_byte(8'h00, 1'b0);
              counted++;
            end
            FAULT_LEAD: begin
              b = ($urandom_range(0, 3) == 0) ? {7'b1111111, 1'($urandom)} : random_cont();
              push_byte(b, 1'b0);
              counted++;
            end
            FAULT_CONT: begin
              len = $urandom_range(2, 6);
              push_byte(random_lead(len), 1'b0);
              cut = $urandom_range(1, len - 1);
              for (int unsigned k = 1; k < cut; k++) push_byte(random_cont(), 1'b0);
              b = 8'($urandom);
              if (b[7:6] == 2'b10) b[6] = 1'b1;
              push_byte(($urandom_range(0, 4) == 0) ? 8'h00 : b, 1'b0);
              counted += cut + 1;
            end
            default: begin
              len = $urandom_range(2, 6);
              push_byte(random_lead(len), 1'b0);
              cut = $urandom_range(1, len - 1);
              for (int unsigned k = 1; k < cut; k++) push_byte(random_cont(), 1'b0);
              counted += cut;
            end
          endcase
          // A few ignored bytes may trail the fault before the string ends.
          if (fault != FAULT_TRUNC) begin
            repeat ($urandom_range(0, 2)) push_byte(8'($urandom), 1'b0);
          end
          break;
        end else begin
          push_byte(random_lead(len), 1'b0);
          for (int unsigned k = 1; k < len; k++) push_byte(random_cont(), 1'b0);
          counted += len;
        end
      end
      byte_queue[$].last = 1'b1;
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (byte_queue.size() != 0 || drv_busy || char_expect.size() != 0) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);

    $display("Sent %0d bytes in %0d random strings plus directed cases; %0d results checked",
             bytes_taken, string_count, results_seen);
    $display("Status counts: ok %0d, bad lead %0d, bad continuation %0d,",
             status_seen[0], status_seen[1], status_seen[2]);
    $display("  truncated %0d, zero %0d", status_seen[3], status_seen[4]);
    if (mismatch_count == 0) begin
      $display("tb_utf8_sequence_assembler_unit passed");
    end else begin
      $display("%0d mismatches in total", mismatch_count);
      $display("tb_utf8_sequence_assembler_unit failed");
    end
    $finish;
  end

endmodule
